### src/bsoc_pkg.sv
package bsoc_pkg;

    localparam int TABLE_POINTS = 11;
    localparam int VOLT_BITS    = 16;

    // Table address width; it also holds the span TABLE_POINTS - 1.
    localparam int IDX_W  = $clog2(TABLE_POINTS);
    localparam int SPAN   = TABLE_POINTS - 1;
    localparam int DEN_W  = VOLT_BITS + IDX_W;
    localparam int PCT_W  = 7;
    localparam int NUM_W  = DEN_W + PCT_W;
    localparam int CNT_W  = $clog2(PCT_W);

    localparam int RES_W  = 10;
    localparam int WT_W   = 9;
    localparam int CUR_W  = 12;
    localparam int SAG_W  = RES_W + CUR_W;
    localparam int PROD_W = VOLT_BITS + WT_W;
    localparam int PIDX_W = 4;
    localparam int PMV_W  = 16;
    localparam int TMV_W  = 16;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = RES_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RESISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT     = 1'b1;

    localparam logic [RES_W-1:0] RES_RESET = 10'd22;
    localparam logic [WT_W-1:0]  WT_RESET  = 9'd205;
    localparam logic [WT_W-1:0]  WT_ONE    = 9'd256;
    localparam int               OCV_RESET = 12000;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    localparam logic [0:0] REQ_SAMPLE = 1'b0;
    localparam logic [0:0] REQ_WRITE  = 1'b1;

endpackage

### src/bsoc_ram.sv
module bsoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/battery_soc_ocv_estimator_unit.sv
// State-of-charge estimator from open-circuit voltage.
// Input channel (i_in_valid / o_in_stall) carries one transaction per item:
// a table write (req_type 1) loads one point of the descending voltage
// table and gives no result; a sample (req_type 0) gives exactly one
// charge_percent transaction on the output channel (o_out_valid /
// i_out_stall).
// A sample removes the resistive sag, updates the smoothed estimate, then
// scans the voltage table one entry per cycle out of a small RAM
// (first point, last point, then segments in order) and finishes with a
// 7-step restoring divider for the interpolation.
// After the accepting edge the sample passes S_SAG, S_MUL, S_FILT and S_TOP;
// an estimate at or above the first point goes to S_DONE, else S_BOT checks
// the last point, else S_SCAN walks the segments and, on a hit, S_PREP,
// S_SCALE and S_DIV follow; S_DONE loads the output register. The block
// takes one sample at a time; the next transaction is accepted only once
// it is back in S_IDLE. A finished result waits in the output register, so
// the next transaction is accepted while the receiver stalls; a later
// result waits until that register is free.
// Reset loads the default resistance (22), weight (205) and an estimate
// of 12000 mV; the table is undefined until written.
module battery_soc_ocv_estimator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bsoc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bsoc_pkg::CFG_DAT_W-1:0]       i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_req_type,
    input  logic [bsoc_pkg::TMV_W-1:0]           i_terminal_mv,
    input  logic [bsoc_pkg::CUR_W-1:0]           i_load_current,
    input  logic [bsoc_pkg::PIDX_W-1:0]          i_point_index,
    input  logic [bsoc_pkg::PMV_W-1:0]           i_point_mv,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bsoc_pkg::PCT_W-1:0]           o_charge_percent
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SAG   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_FILT  = 4'd3;
    localparam logic [3:0] S_TOP   = 4'd4;
    localparam logic [3:0] S_BOT   = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_PREP  = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    localparam int VB = bsoc_pkg::VOLT_BITS;
    localparam int IW = bsoc_pkg::IDX_W;
    localparam int DW = bsoc_pkg::DEN_W;
    localparam int NW = bsoc_pkg::NUM_W;
    localparam int PW = bsoc_pkg::PCT_W;
    localparam int CW = bsoc_pkg::CNT_W;

    localparam logic [IW-1:0] SPAN_C = IW'(bsoc_pkg::SPAN);
    localparam logic [IW-1:0] ONE_C  = IW'(1);

    logic [3:0]                       r_state, n_state;
    logic [bsoc_pkg::RES_W-1:0]       r_res, n_res;
    logic [bsoc_pkg::WT_W-1:0]        r_wt, n_wt;
    logic [VB-1:0]                    r_filt, n_filt;
    logic [bsoc_pkg::TMV_W-1:0]       r_vt, n_vt;
    logic [bsoc_pkg::CUR_W-1:0]       r_cur, n_cur;
    logic [VB-1:0]                    r_fresh, n_fresh;
    logic [bsoc_pkg::PROD_W-1:0]      r_prod, n_prod;
    logic [VB-1:0]                    r_hi, n_hi;
    logic [IW-1:0]                    r_k, n_k;
    logic [VB-1:0]                    r_d, n_d;
    logic [VB-1:0]                    r_r, n_r;
    logic [DW-1:0]                    r_m, n_m;
    logic [NW-1:0]                    r_rem, n_rem;
    logic [NW-1:0]                    r_dsh, n_dsh;
    logic [PW-1:0]                    r_q, n_q;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic [PW-1:0]                    r_pct, n_pct;
    logic                             r_out_valid, n_out_valid;
    logic [PW-1:0]                    r_out_pct, n_out_pct;

    logic                             in_acc;
    logic                             ram_we;
    logic [IW-1:0]                    ram_raddr;
    logic [VB-1:0]                    ram_rdata;
    logic [bsoc_pkg::SAG_W-1:0]       sag;
    logic [bsoc_pkg::SAG_W-1:0]       vt_ext;
    logic [bsoc_pkg::WT_W-1:0]        w_sat;
    logic [bsoc_pkg::WT_W-1:0]        w_new;
    logic [bsoc_pkg::PROD_W:0]        blend;
    logic [IW-1:0]                    span_k;
    logic                             q_bit;

    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign ram_we = in_acc && (i_req_type == bsoc_pkg::REQ_WRITE)
                    && (32'(i_point_index) < bsoc_pkg::TABLE_POINTS);

    bsoc_ram #(
        .WIDTH (VB),
        .DEPTH (bsoc_pkg::TABLE_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IW'(i_point_index)),
        .i_wdata (VB'(i_point_mv)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign sag    = bsoc_pkg::SAG_W'(r_cur) * bsoc_pkg::SAG_W'(r_res);
    assign vt_ext = bsoc_pkg::SAG_W'(r_vt);
    assign w_sat  = (r_wt > bsoc_pkg::WT_ONE) ? bsoc_pkg::WT_ONE : r_wt;
    assign w_new  = bsoc_pkg::WT_ONE - w_sat;
    assign blend  = (bsoc_pkg::PROD_W + 1)'(r_prod)
                    + (bsoc_pkg::PROD_W + 1)'(w_new) * (bsoc_pkg::PROD_W + 1)'(r_fresh)
                    + (bsoc_pkg::PROD_W + 1)'(128);
    assign span_k = SPAN_C - r_k;
    assign q_bit  = (r_rem >= r_dsh);

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_wt        = r_wt;
        n_filt      = r_filt;
        n_vt        = r_vt;
        n_cur       = r_cur;
        n_fresh     = r_fresh;
        n_prod      = r_prod;
        n_hi        = r_hi;
        n_k         = r_k;
        n_d         = r_d;
        n_r         = r_r;
        n_m         = r_m;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_pct       = r_pct;
        n_out_valid = r_out_valid;
        n_out_pct   = r_out_pct;
        ram_raddr   = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsoc_pkg::CFG_RESISTANCE: n_res = i_cfg_wdata;
                bsoc_pkg::CFG_WEIGHT:     n_wt  = i_cfg_wdata[bsoc_pkg::WT_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req_type == bsoc_pkg::REQ_SAMPLE)) begin
                    n_vt    = i_terminal_mv;
                    n_cur   = i_load_current;
                    n_state = S_SAG;
                end
            end
            S_SAG: begin
                n_fresh = (vt_ext > sag) ? VB'(vt_ext - sag) : '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = bsoc_pkg::PROD_W'(w_sat) * bsoc_pkg::PROD_W'(r_filt);
                n_state = S_FILT;
            end
            S_FILT: begin
                // The blend never exceeds the larger operand, so the top bits are zero.
                n_filt    = blend[VB+7:8];
                ram_raddr = '0;
                n_state   = S_TOP;
            end
            S_TOP: begin
                if (r_filt >= ram_rdata) begin
                    n_pct   = bsoc_pkg::PCT_FULL;
                    n_state = S_DONE;
                end else begin
                    n_hi      = ram_rdata;
                    ram_raddr = SPAN_C;
                    n_state   = S_BOT;
                end
            end
            S_BOT: begin
                if (r_filt <= ram_rdata) begin
                    n_pct   = bsoc_pkg::PCT_EMPTY;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = ONE_C;
                    n_k       = ONE_C;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // The RAM output holds entry k, the lower end of the segment.
                if ((ram_rdata <= r_filt) && (r_filt < r_hi)) begin
                    n_d     = r_hi - ram_rdata;
                    n_r     = r_filt - ram_rdata;
                    n_state = S_PREP;
                end else if (r_k == SPAN_C) begin
                    n_pct   = bsoc_pkg::PCT_EMPTY;
                    n_state = S_DONE;
                end else begin
                    n_hi      = ram_rdata;
                    n_k       = r_k + ONE_C;
                    ram_raddr = r_k + ONE_C;
                end
            end
            S_PREP: begin
                n_m   = DW'(span_k) * DW'(r_d) + DW'(r_r);
                n_dsh = NW'(DW'(SPAN_C) * DW'(r_d)) << (PW - 1);
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_rem   = NW'(r_m) * NW'(bsoc_pkg::PCT_FULL);
                n_q     = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (q_bit) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = {r_q[PW-2:0], q_bit};
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(PW - 1)) begin
                    n_pct   = {r_q[PW-2:0], q_bit};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_pct   = r_pct;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= bsoc_pkg::RES_RESET;
            r_wt        <= bsoc_pkg::WT_RESET;
            r_filt      <= VB'(bsoc_pkg::OCV_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_wt        <= n_wt;
            r_filt      <= n_filt;
            r_out_valid <= n_out_valid;
        end
        r_vt      <= n_vt;
        r_cur     <= n_cur;
        r_fresh   <= n_fresh;
        r_prod    <= n_prod;
        r_hi      <= n_hi;
        r_k       <= n_k;
        r_d       <= n_d;
        r_r       <= n_r;
        r_m       <= n_m;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_q       <= n_q;
        r_cnt     <= n_cnt;
        r_pct     <= n_pct;
        r_out_pct <= n_out_pct;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_charge_percent = r_out_pct;

    // A table write completes at once and leaves the block ready.
    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req_type == bsoc_pkg::REQ_WRITE))
        |=> !o_in_stall)
        else $error("table write left the block busy");

    // A sample always starts the estimator sequence.
    a_sample_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req_type == bsoc_pkg::REQ_SAMPLE))
        |=> o_in_stall)
        else $error("sample accepted without starting the estimate");

    // The interpolation can never exceed full charge.
    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_charge_percent <= bsoc_pkg::PCT_FULL))
        else $error("charge percent above full");

    // A result is delivered only from the final state of a sample.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the final state");

endmodule

### bench/battery_soc_ocv_estimator_unit_test.sv
module battery_soc_ocv_estimator_unit_test;

    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int MAX_REPORTS   = 20;

    typedef struct packed {
        logic [0:0]                  req;
        logic [bsoc_pkg::TMV_W-1:0]  vt;
        logic [bsoc_pkg::CUR_W-1:0]  cur;
        logic [bsoc_pkg::PIDX_W-1:0] idx;
        logic [bsoc_pkg::PMV_W-1:0]  mv;
    } t_soc_txn;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [bsoc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bsoc_pkg::CFG_DAT_W-1:0] i_cfg_wdata = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_req_type = 1'b0;
    logic [bsoc_pkg::TMV_W-1:0]     i_terminal_mv = '0;
    logic [bsoc_pkg::CUR_W-1:0]     i_load_current = '0;
    logic [bsoc_pkg::PIDX_W-1:0]    i_point_index = '0;
    logic [bsoc_pkg::PMV_W-1:0]     i_point_mv = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [bsoc_pkg::PCT_W-1:0]     o_charge_percent;

    // Local copy of the block's state and settings.
    logic [bsoc_pkg::RES_W-1:0]     model_res = bsoc_pkg::RES_RESET;
    logic [bsoc_pkg::WT_W-1:0]      model_wt = bsoc_pkg::WT_RESET;
    logic [bsoc_pkg::VOLT_BITS-1:0] model_ocv = bsoc_pkg::VOLT_BITS'(bsoc_pkg::OCV_RESET);
    logic [bsoc_pkg::VOLT_BITS-1:0] model_table [bsoc_pkg::TABLE_POINTS] = '{default: '0};
    logic [bsoc_pkg::PCT_W-1:0]     pending_charge [$];
    logic [bsoc_pkg::PCT_W-1:0]     charge_want;

    int          mismatch_count = 0;
    int          clk_cycles = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_span = 0;

    battery_soc_ocv_estimator_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        clk_cycles <= clk_cycles + 1;
        if (clk_cycles > LIMIT_CYCLES) begin
            $display("FAIL battery_soc_ocv_estimator_unit");
            $finish;
        end
    end

    // The receiver switches to a new, randomly chosen stall pattern whenever the current span runs out.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 160);
        end else begin
            stall_span = stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((clk_cycles % 23) < 15);
        endcase
    end

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH %s: got %0d, expected %0d, cycle %0d",
                     what, got, want, clk_cycles);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_charge.size() == 0) begin
                report_mismatch("charge_percent with nothing pending", o_charge_percent, -1);
            end else begin
                charge_want = pending_charge.pop_front();
                if (o_charge_percent !== charge_want)
                    report_mismatch("charge_percent", o_charge_percent, charge_want);
            end
        end
    end

    function automatic logic [bsoc_pkg::VOLT_BITS-1:0] smooth_ocv(
            logic [bsoc_pkg::TMV_W-1:0] vt, logic [bsoc_pkg::CUR_W-1:0] cur);
        longint unsigned sag, fresh, w, mix;
        sag = longint'(cur) * longint'(model_res);
        fresh = (vt > sag) ? vt - sag : 0;
        w = (model_wt > bsoc_pkg::WT_ONE) ? bsoc_pkg::WT_ONE : model_wt;
        mix = (w * model_ocv + (256 - w) * fresh + 128) >> 8;
        return mix[bsoc_pkg::VOLT_BITS-1:0];
    endfunction

    function automatic logic [bsoc_pkg::PCT_W-1:0] charge_from_ocv(
            logic [bsoc_pkg::VOLT_BITS-1:0] v);
        longint unsigned d, r, q;
        if (v >= model_table[0])
            return bsoc_pkg::PCT_FULL;
        if (v <= model_table[bsoc_pkg::SPAN])
            return bsoc_pkg::PCT_EMPTY;
        // The first segment that holds the estimate wins, even in a scrambled table.
        for (int k = 1; k < bsoc_pkg::TABLE_POINTS; k++) begin
            if (model_table[k] <= v && v < model_table[k-1]) begin
                d = model_table[k-1] - model_table[k];
                r = v - model_table[k];
                q = (100 * ((bsoc_pkg::SPAN - k) * d + r)) / (bsoc_pkg::SPAN * d);
                return q[bsoc_pkg::PCT_W-1:0];
            end
        end
        return bsoc_pkg::PCT_EMPTY;
    endfunction

    task automatic apply_transaction(t_soc_txn t);
        if (t.req == bsoc_pkg::REQ_WRITE) begin
            if (t.idx < bsoc_pkg::TABLE_POINTS)
                model_table[t.idx] = t.mv;
        end else begin
            model_ocv = smooth_ocv(t.vt, t.cur);
            pending_charge.push_back(charge_from_ocv(model_ocv));
        end
    endtask

    function automatic t_soc_txn sample_txn(logic [bsoc_pkg::TMV_W-1:0] vt,
                                            logic [bsoc_pkg::CUR_W-1:0] cur);
        t_soc_txn t;
        t.req = bsoc_pkg::REQ_SAMPLE;
        t.vt = vt;
        t.cur = cur;
        t.idx = bsoc_pkg::PIDX_W'($urandom);
        t.mv = bsoc_pkg::PMV_W'($urandom);
        return t;
    endfunction

    function automatic t_soc_txn write_txn(logic [bsoc_pkg::PIDX_W-1:0] idx,
                                           logic [bsoc_pkg::PMV_W-1:0] mv);
        t_soc_txn t;
        t.req = bsoc_pkg::REQ_WRITE;
        t.vt = bsoc_pkg::TMV_W'($urandom);
        t.cur = bsoc_pkg::CUR_W'($urandom);
        t.idx = idx;
        t.mv = mv;
        return t;
    endfunction

    // A sample whose compensated voltage lands near the span of the table.
    function automatic t_soc_txn tracking_sample();
        int lo_mv, hi_mv, target, cur_max, cur;
        lo_mv = 65535;
        hi_mv = 0;
        foreach (model_table[i]) begin
            if (model_table[i] < lo_mv)
                lo_mv = model_table[i];
            if (model_table[i] > hi_mv)
                hi_mv = model_table[i];
        end
        lo_mv = (lo_mv > 300) ? lo_mv - 300 : 0;
        hi_mv = (hi_mv < 65235) ? hi_mv + 300 : 65535;
        target = $urandom_range(hi_mv, lo_mv);
        cur_max = (model_res == 0) ? 4095 : (65535 - target) / int'(model_res);
        if (cur_max > 4095)
            cur_max = 4095;
        cur = $urandom_range(cur_max, 0);
        return sample_txn(bsoc_pkg::TMV_W'(target + cur * int'(model_res)),
                          bsoc_pkg::CUR_W'(cur));
    endfunction

    task automatic send_item(t_soc_txn t);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= t.req;
        i_terminal_mv <= t.vt;
        i_load_current <= t.cur;
        i_point_index <= t.idx;
        i_point_mv <= t.mv;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        apply_transaction(t);
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_paced(t_soc_txn t);
        send_item(t);
        if (!no_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                pause_sender(($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 6));
            end
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_charge.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bsoc_pkg::CFG_IDX_W-1:0] idx,
                             logic [bsoc_pkg::CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bsoc_pkg::CFG_RESISTANCE)
            model_res = data;
        else
            model_wt = data[bsoc_pkg::WT_W-1:0];
    endtask

    task automatic set_config(int res, int wt);
        wait_for_results();
        write_reg(bsoc_pkg::CFG_RESISTANCE, bsoc_pkg::CFG_DAT_W'(res));
        write_reg(bsoc_pkg::CFG_WEIGHT, bsoc_pkg::CFG_DAT_W'(wt));
    endtask

    task automatic load_falling_table();
        int mv, step;
        mv = ($urandom_range(0, 3) == 0) ? $urandom_range(20000, 65535)
                                         : $urandom_range(3400, 4400);
        step = mv / 12;
        for (int i = 0; i < bsoc_pkg::TABLE_POINTS; i++) begin
            send_item(write_txn(bsoc_pkg::PIDX_W'(i), bsoc_pkg::PMV_W'(mv)));
            mv = mv - $urandom_range(0, step);
        end
    endtask

    task automatic load_scrambled_table();
        for (int i = 0; i < bsoc_pkg::TABLE_POINTS; i++)
            send_item(write_txn(bsoc_pkg::PIDX_W'(i), bsoc_pkg::PMV_W'($urandom)));
    endtask

    task automatic test_table_load();
        for (int i = 0; i < bsoc_pkg::TABLE_POINTS; i++)
            send_item(write_txn(bsoc_pkg::PIDX_W'(i), bsoc_pkg::PMV_W'(4200 - 120 * i)));
        // Indexes past the last point must leave the table alone.
        send_item(write_txn(4'd11, 16'hFFFF));
        send_item(write_txn(4'd15, 16'h0000));
    endtask

    task automatic test_reset_settings();
        send_item(sample_txn(16'd4100, 12'd5));
        send_item(sample_txn(16'hFFFF, 12'd0));
        send_item(sample_txn(16'd0, 12'hFFF));
    endtask

    // With no sag and no smoothing the estimate equals the terminal voltage.
    task automatic test_exact_points();
        set_config(0, 0);
        send_item(sample_txn(16'd4200, 12'hFFF));
        send_item(sample_txn(16'd3000, 12'd0));
        send_item(sample_txn(16'd3600, 12'd1));
        send_item(sample_txn(16'd3960, 12'd2));
        send_item(sample_txn(16'd3601, 12'd3));
        send_item(sample_txn(16'd4199, 12'd4));
        send_item(sample_txn(16'd2999, 12'd5));
    endtask

    task automatic test_extreme_settings();
        set_config(1023, 256);
        send_item(sample_txn(16'hFFFF, 12'hFFF));
        set_config(1023, 511);
        send_item(sample_txn(16'd0, 12'd0));
        set_config(1023, 0);
        send_item(sample_txn(16'hFFFF, 12'd64));
        send_item(sample_txn(16'hFFFF, 12'hFFF));
    endtask

    task automatic test_random_traffic();
        int pick;
        for (int p = 0; p < PHASES; p++) begin
            no_gaps = (p == 0 || p == 5);
            case (p)
                0: set_config(bsoc_pkg::RES_RESET, bsoc_pkg::WT_RESET);
                1: set_config(0, 0);
                2: set_config(1023, 256);
                3: set_config($urandom_range(0, 1023), $urandom_range(0, 256));
                4: set_config($urandom_range(0, 40), 511);
                5: set_config($urandom_range(0, 1023), $urandom_range(0, 256));
                6: set_config(1, 1);
                default: set_config($urandom_range(0, 1023), $urandom_range(0, 511));
            endcase
            if (p % 3 == 2)
                load_scrambled_table();
            else
                load_falling_table();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 86)
                    send_paced(tracking_sample());
                else if (pick < 89)
                    send_paced(write_txn(bsoc_pkg::PIDX_W'($urandom_range(0, 15)),
                                         bsoc_pkg::PMV_W'($urandom)));
                else
                    send_paced(($urandom_range(0, 1) == 0)
                               ? sample_txn(bsoc_pkg::TMV_W'($urandom),
                                            bsoc_pkg::CUR_W'($urandom))
                               : write_txn(bsoc_pkg::PIDX_W'($urandom),
                                           bsoc_pkg::PMV_W'($urandom)));
                // Now and then the sender holds off until the output side is empty.
                if ($urandom_range(0, 99) == 0)
                    wait_for_results();
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_table_load();
        test_reset_settings();
        test_exact_points();
        test_extreme_settings();
        test_random_traffic();
        wait_for_results();
        if (mismatch_count == 0 && pending_charge.size() == 0)
            $display("PASS battery_soc_ocv_estimator_unit");
        else
            $display("FAIL battery_soc_ocv_estimator_unit");
        $finish;
    end

endmodule

### battery_soc_ocv_estimator_unit.f
src/bsoc_pkg.sv
src/bsoc_ram.sv
src/battery_soc_ocv_estimator_unit.sv
bench/battery_soc_ocv_estimator_unit_test.sv
